FILE: hdl/drodo_pkg.sv
// shared types, constants and tables of the dead-reckoning odometry block
`timescale 1ns / 1ps
package drodo_pkg;

	// default build parameters
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANGLE_BITS_DEF   = 16;

	// datapath widths
	localparam int CORDIC_W = 37;
	localparam int MUL_W    = 34;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int TPS_W    = 30;
	localparam int DIVN_W   = 62;
	localparam int DCNT_W   = 5;

	// divider retires two quotient bits a cycle
	localparam logic [DCNT_W-1:0] DIV_ITERS = DCNT_W'(DIVN_W / 2);

	// reset tick rate and cordic start value (0.607252935 in q1.30)
	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
	localparam logic signed [CORDIC_W-1:0] ONE_Q30 = CORDIC_W'(1073741824);

	// atan(2^-i) with 2^32 per full circle
	localparam logic [31:0] ATAN_TABLE [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// item kinds
	localparam logic CMD_DISTANCE    = 1'b0;
	localparam logic CMD_ORIENTATION = 1'b1;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_QA,
		OP_QB,
		OP_QC,
		OP_QD,
		OP_VLOAD,
		OP_ITER,
		OP_HEAD,
		OP_DLOAD,
		OP_DIVLD,
		OP_RUN,
		OP_MX,
		OP_MY,
		OP_VX,
		OP_VY,
		OP_VEND,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic cordic_done;
		logic div_done;
	} dp_sts_t;

endpackage

FILE: hdl/drodo_if.sv
// request and configuration channel interfaces
`timescale 1ns / 1ps
interface drodo_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [31:0]        time_stamp;
	logic signed [31:0] distance_total;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] gyro_yaw_rate;

	modport source (output valid, cmd, time_stamp, distance_total, quat_x, quat_y,
		quat_z, quat_w, gyro_yaw_rate, input ready);
	modport sink (input valid, cmd, time_stamp, distance_total, quat_x, quat_y,
		quat_z, quat_w, gyro_yaw_rate, output ready);
endinterface

interface drodo_out_if;
	logic               valid;
	logic               ready;
	logic signed [39:0] pos_x;
	logic signed [39:0] pos_y;
	logic signed [23:0] vel_x;
	logic signed [23:0] vel_y;
	logic [15:0]        heading_out;
	logic signed [15:0] rate_out;
	logic               zero_interval;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, heading_out, rate_out,
		zero_interval, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, heading_out, rate_out,
		zero_interval, output ready);
endinterface

interface drodo_cfg_if;
	logic        valid;
	logic        ready;
	logic [29:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: hdl/drodo_ctrl.sv
// sequencer for orientation and distance requests
`timescale 1ns / 1ps
module drodo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_cmd,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  drodo_pkg::dp_sts_t sts,
	output drodo_pkg::dp_cmd_t cmd
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_QA    = 17'b00000000000000010,
		S_QB    = 17'b00000000000000100,
		S_QC    = 17'b00000000000001000,
		S_QD    = 17'b00000000000010000,
		S_VLOAD = 17'b00000000000100000,
		S_VEC   = 17'b00000000001000000,
		S_HEAD  = 17'b00000000010000000,
		S_DLOAD = 17'b00000000100000000,
		S_DIVLD = 17'b00000001000000000,
		S_RUN   = 17'b00000010000000000,
		S_MX    = 17'b00000100000000000,
		S_MY    = 17'b00001000000000000,
		S_VX    = 17'b00010000000000000,
		S_VY    = 17'b00100000000000000,
		S_VEND  = 17'b01000000000000000,
		S_OUT   = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = drodo_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op  = drodo_pkg::OP_LATCH;
					state_d = (in_cmd == drodo_pkg::CMD_ORIENTATION) ? S_QA : S_DLOAD;
				end
			end
			S_QA: begin
				cmd.op  = drodo_pkg::OP_QA;
				state_d = S_QB;
			end
			S_QB: begin
				cmd.op  = drodo_pkg::OP_QB;
				state_d = S_QC;
			end
			S_QC: begin
				cmd.op  = drodo_pkg::OP_QC;
				state_d = S_QD;
			end
			S_QD: begin
				cmd.op  = drodo_pkg::OP_QD;
				state_d = S_VLOAD;
			end
			S_VLOAD: begin
				cmd.op  = drodo_pkg::OP_VLOAD;
				state_d = S_VEC;
			end
			S_VEC: begin
				cmd.op = drodo_pkg::OP_ITER;
				if (sts.cordic_done) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.op  = drodo_pkg::OP_HEAD;
				state_d = S_IDLE;
			end
			S_DLOAD: begin
				cmd.op  = drodo_pkg::OP_DLOAD;
				state_d = S_DIVLD;
			end
			S_DIVLD: begin
				cmd.op  = drodo_pkg::OP_DIVLD;
				state_d = S_RUN;
			end
			S_RUN: begin
				cmd.op = drodo_pkg::OP_RUN;
				if (sts.cordic_done && sts.div_done) begin
					state_d = S_MX;
				end
			end
			S_MX: begin
				cmd.op  = drodo_pkg::OP_MX;
				state_d = S_MY;
			end
			S_MY: begin
				cmd.op  = drodo_pkg::OP_MY;
				state_d = S_VX;
			end
			S_VX: begin
				cmd.op  = drodo_pkg::OP_VX;
				state_d = S_VY;
			end
			S_VY: begin
				cmd.op  = drodo_pkg::OP_VY;
				state_d = S_VEND;
			end
			S_VEND: begin
				cmd.op  = drodo_pkg::OP_VEND;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.op  = drodo_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a new result only comes from the output state
	a_out_from_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	// distance path leaves the run phase only with both units finished
	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MX) |-> $past(state_q == S_RUN && sts.cordic_done && sts.div_done))
		else $error("run phase left early");

	// heading is stored only after the vectoring pass completes
	a_head_after_vec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD) |-> $past(state_q == S_VEC && sts.cordic_done))
		else $error("heading stored before cordic done");

	// no request taken while busy
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("request accepted while busy");

endmodule

FILE: hdl/drodo_dp.sv
// odometry datapath: multiplier, shared cordic, divider and state registers
`timescale 1ns / 1ps
module drodo_dp #(
	parameter int CORDIC_STEPS = drodo_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_BITS   = drodo_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  drodo_pkg::dp_cmd_t cmd,
	output drodo_pkg::dp_sts_t sts,
	input  logic [31:0]        time_stamp,
	input  logic signed [31:0] distance_total,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] gyro_yaw_rate,
	input  logic               cfg_we,
	input  logic [29:0]        cfg_data,
	output logic signed [39:0] pos_x,
	output logic signed [39:0] pos_y,
	output logic signed [23:0] vel_x,
	output logic signed [23:0] vel_y,
	output logic [15:0]        heading_out,
	output logic signed [15:0] rate_out,
	output logic               zero_interval
);

	localparam int AB = ANGLE_BITS;
	localparam int ZW = AB + 1;
	localparam int IW = $clog2(CORDIC_STEPS + 1);
	localparam int CW = drodo_pkg::CORDIC_W;
	localparam int MW = drodo_pkg::MUL_W;
	localparam int PW = drodo_pkg::PROD_W;
	localparam int UP = (AB >= 16) ? AB - 16 : 0;
	localparam int DN = (AB < 16) ? 16 - AB : 0;
	localparam logic signed [ZW-1:0] QUARTER = ZW'(1 << (AB - 2));
	localparam logic signed [ZW-1:0] HALF    = ZW'(1 << (AB - 1));
	localparam logic [IW-1:0] STEPS_LAST = IW'(CORDIC_STEPS);
	localparam logic signed [PW-1:0] RND22 = PW'(1) <<< 21;
	localparam logic signed [PW-1:0] RND30 = PW'(1) <<< 29;

	// rounded arctangent step at the angle resolution
	function automatic logic signed [ZW-1:0] step_angle(input logic [4:0] idx);
		logic [32:0] t;
		begin
			t = {1'b0, drodo_pkg::ATAN_TABLE[idx]} + (33'd1 << (31 - AB));
			step_angle = ZW'(t >> (32 - AB));
		end
	endfunction

	// 16-bit heading to cordic angle and back
	function automatic logic [AB-1:0] to_angle(input logic [15:0] h);
		to_angle = AB'((32'(h) << UP) >> DN);
	endfunction

	function automatic logic [15:0] to_head(input logic [AB-1:0] a);
		to_head = 16'((32'(a) << DN) >> UP);
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [46:0] v);
		if (v > 47'sd549755813887) begin
			sat40 = 40'sh7FFFFFFFFF;
		end else if (v < -47'sd549755813888) begin
			sat40 = 40'sh8000000000;
		end else begin
			sat40 = v[39:0];
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
		if (v > 38'sd8388607) begin
			sat24 = 24'sh7FFFFF;
		end else if (v < -38'sd8388608) begin
			sat24 = 24'sh800000;
		end else begin
			sat24 = v[23:0];
		end
	endfunction

	// request registers
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q, yaw_q;
	logic [31:0]        dist_in_q, time_in_q;
	logic signed [31:0] delta_q;
	logic               zero_q;

	// architectural state
	logic [29:0]        tps_q;
	logic [31:0]        prev_dist_q, prev_time_q;
	logic signed [39:0] pos_x_q, pos_y_q;
	logic [15:0]        heading_q;
	logic signed [15:0] turn_rate_q;

	// multiplier
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;

	// quaternion sums
	logic signed [CW-1:0] num_q, den_q;

	// cordic
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [IW-1:0]        iter_q;
	logic                 vec_mode_q, neg_q, degen_q;

	// divider
	logic [32:0]          rem_q;
	logic [drodo_pkg::DIVN_W-1:0] nq_q;
	logic [drodo_pkg::DCNT_W-1:0] dcnt_q;

	// velocity
	logic signed [23:0] vx_q, vy_q;

	// output register
	logic signed [39:0] o_pos_x_q, o_pos_y_q;
	logic signed [23:0] o_vel_x_q, o_vel_y_q;
	logic [15:0]        o_head_q;
	logic signed [15:0] o_rate_q;
	logic               o_zero_q;

	// cordic step terms
	logic signed [CW-1:0] sx, sy;
	logic signed [ZW-1:0] ang;
	logic                 turn_neg;
	logic                 cordic_done;

	assign sx          = cx_q >>> iter_q;
	assign sy          = cy_q >>> iter_q;
	assign ang         = step_angle(5'(iter_q));
	assign turn_neg    = vec_mode_q ? cy_q[CW-1] : !cz_q[ZW-1];
	assign cordic_done = (iter_q == STEPS_LAST);

	// vectoring start values
	logic signed [CW-1:0] den_s, xd, yd;

	assign den_s = den_q + $signed(prod_q[CW-1:0]);
	assign xd    = drodo_pkg::ONE_Q30 - (den_s <<< 1);
	assign yd    = num_q <<< 1;

	// rotation start angle folded into the right half plane
	logic [AB-1:0]        a_rot;
	logic signed [ZW-1:0] za;

	assign a_rot = to_angle(heading_q);
	assign za    = $signed({a_rot[AB-1], a_rot});

	// signed cosine and sine
	logic signed [CW-1:0] cos_f, sin_f;
	logic signed [MW-1:0] cos_m, sin_m;

	assign cos_f = neg_q ? -cx_q : cx_q;
	assign sin_f = neg_q ? -cy_q : cy_q;
	assign cos_m = cos_f[MW-1:0];
	assign sin_m = sin_f[MW-1:0];

	// speed magnitude and sign
	logic [32:0]        abs_delta;
	logic [30:0]        mag_sat;
	logic signed [31:0] speed;

	assign abs_delta = delta_q[31] ? -{delta_q[31], delta_q} : {delta_q[31], delta_q};
	assign mag_sat   = (|nq_q[drodo_pkg::DIVN_W-1:31]) ? 31'h7FFFFFFF : nq_q[30:0];
	assign speed     = delta_q[31] ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

	// rounding of products
	logic signed [PW-1:0] r22, r30;
	logic signed [46:0]   sum_x, sum_y;

	assign r22   = (prod_q + RND22) >>> 22;
	assign r30   = (prod_q + RND30) >>> 30;
	assign sum_x = 47'(pos_x_q) + r22[46:0];
	assign sum_y = 47'(pos_y_q) + r22[46:0];

	// two restoring divide steps
	logic [32:0] r1, r2, r1s, r2s;
	logic        ge1, ge2;

	assign r1  = {rem_q[31:0], nq_q[drodo_pkg::DIVN_W-1]};
	assign ge1 = (r1 >= {1'b0, time_in_q - prev_time_q});
	assign r1s = ge1 ? r1 - {1'b0, time_in_q - prev_time_q} : r1;
	assign r2  = {r1s[31:0], nq_q[drodo_pkg::DIVN_W-2]};
	assign ge2 = (r2 >= {1'b0, time_in_q - prev_time_q});
	assign r2s = ge2 ? r2 - {1'b0, time_in_q - prev_time_q} : r2;

	assign sts.cordic_done = cordic_done;
	assign sts.div_done    = (dcnt_q == drodo_pkg::DIV_ITERS);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			drodo_pkg::OP_QA: begin
				mul_a = MW'(qw_q);
				mul_b = MW'(qz_q);
			end
			drodo_pkg::OP_QB: begin
				mul_a = MW'(qx_q);
				mul_b = MW'(qy_q);
			end
			drodo_pkg::OP_QC: begin
				mul_a = MW'(qy_q);
				mul_b = MW'(qy_q);
			end
			drodo_pkg::OP_QD: begin
				mul_a = MW'(qz_q);
				mul_b = MW'(qz_q);
			end
			drodo_pkg::OP_DLOAD: begin
				mul_a = $signed(MW'(abs_delta));
				mul_b = $signed(MW'(tps_q));
			end
			drodo_pkg::OP_MX: begin
				mul_a = MW'(delta_q);
				mul_b = cos_m;
			end
			drodo_pkg::OP_MY: begin
				mul_a = MW'(delta_q);
				mul_b = sin_m;
			end
			drodo_pkg::OP_VX: begin
				mul_a = MW'(speed);
				mul_b = cos_m;
			end
			drodo_pkg::OP_VY: begin
				mul_a = MW'(speed);
				mul_b = sin_m;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// request capture and quaternion sums
	always_ff @(posedge clk) begin
		if (cmd.op == drodo_pkg::OP_LATCH) begin
			qx_q      <= quat_x;
			qy_q      <= quat_y;
			qz_q      <= quat_z;
			qw_q      <= quat_w;
			yaw_q     <= gyro_yaw_rate;
			dist_in_q <= distance_total;
			time_in_q <= time_stamp;
			delta_q   <= distance_total - $signed(prev_dist_q);
			zero_q    <= (time_stamp == prev_time_q);
		end
		if (cmd.op == drodo_pkg::OP_QB) begin
			num_q <= $signed(prod_q[CW-1:0]);
		end
		if (cmd.op == drodo_pkg::OP_QC) begin
			num_q <= num_q + $signed(prod_q[CW-1:0]);
		end
		if (cmd.op == drodo_pkg::OP_QD) begin
			den_q <= $signed(prod_q[CW-1:0]);
		end
	end

	// shared cordic: vectoring for heading, rotation for sine and cosine
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			drodo_pkg::OP_VLOAD: begin
				vec_mode_q <= 1'b1;
				degen_q    <= (xd == '0) && (yd == '0);
				if (xd[CW-1]) begin
					cx_q <= -xd;
					cy_q <= -yd;
					cz_q <= HALF;
				end else begin
					cx_q <= xd;
					cy_q <= yd;
					cz_q <= '0;
				end
			end
			drodo_pkg::OP_DLOAD: begin
				vec_mode_q <= 1'b0;
				cx_q       <= drodo_pkg::CORDIC_GAIN;
				cy_q       <= '0;
				if (za > QUARTER) begin
					cz_q  <= za - HALF;
					neg_q <= 1'b1;
				end else if (za < -QUARTER) begin
					cz_q  <= za + HALF;
					neg_q <= 1'b1;
				end else begin
					cz_q  <= za;
					neg_q <= 1'b0;
				end
			end
			drodo_pkg::OP_ITER, drodo_pkg::OP_RUN: begin
				if (!cordic_done) begin
					if (turn_neg) begin
						cx_q <= cx_q - sy;
						cy_q <= cy_q + sx;
						cz_q <= cz_q - ang;
					end else begin
						cx_q <= cx_q + sy;
						cy_q <= cy_q - sx;
						cz_q <= cz_q + ang;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// cordic step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.op == drodo_pkg::OP_VLOAD || cmd.op == drodo_pkg::OP_DLOAD) begin
			iter_q <= '0;
		end else if ((cmd.op == drodo_pkg::OP_ITER || cmd.op == drodo_pkg::OP_RUN)
				&& !cordic_done) begin
			iter_q <= iter_q + IW'(1);
		end
	end

	// divider datapath, two quotient bits a cycle
	always_ff @(posedge clk) begin
		if (cmd.op == drodo_pkg::OP_DIVLD) begin
			rem_q <= '0;
			nq_q  <= prod_q[drodo_pkg::DIVN_W-1:0];
		end else if (cmd.op == drodo_pkg::OP_RUN && !sts.div_done) begin
			rem_q <= r2s;
			nq_q  <= {nq_q[drodo_pkg::DIVN_W-3:0], ge1, ge2};
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.op == drodo_pkg::OP_DIVLD) begin
			dcnt_q <= '0;
		end else if (cmd.op == drodo_pkg::OP_RUN && !sts.div_done) begin
			dcnt_q <= dcnt_q + drodo_pkg::DCNT_W'(1);
		end
	end

	// velocity registers
	always_ff @(posedge clk) begin
		if (cmd.op == drodo_pkg::OP_VY) begin
			vx_q <= zero_q ? '0 : sat24(r30[37:0]);
		end
		if (cmd.op == drodo_pkg::OP_VEND) begin
			vy_q <= zero_q ? '0 : sat24(r30[37:0]);
		end
	end

	// odometry state and tick rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= drodo_pkg::TPS_RESET;
			prev_dist_q <= '0;
			prev_time_q <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= '0;
			turn_rate_q <= '0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			unique case (cmd.op)
				drodo_pkg::OP_HEAD: begin
					heading_q   <= degen_q ? '0 : to_head(cz_q[AB-1:0]);
					turn_rate_q <= yaw_q;
				end
				drodo_pkg::OP_MY: begin
					pos_x_q <= sat40(sum_x);
				end
				drodo_pkg::OP_VX: begin
					pos_y_q <= sat40(sum_y);
				end
				drodo_pkg::OP_VEND: begin
					prev_dist_q <= dist_in_q;
					prev_time_q <= time_in_q;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.op == drodo_pkg::OP_OUT) begin
			o_pos_x_q <= pos_x_q;
			o_pos_y_q <= pos_y_q;
			o_vel_x_q <= vx_q;
			o_vel_y_q <= vy_q;
			o_head_q  <= heading_q;
			o_rate_q  <= turn_rate_q;
			o_zero_q  <= zero_q;
		end
	end

	assign pos_x         = o_pos_x_q;
	assign pos_y         = o_pos_y_q;
	assign vel_x         = o_vel_x_q;
	assign vel_y         = o_vel_y_q;
	assign heading_out   = o_head_q;
	assign rate_out      = o_rate_q;
	assign zero_interval = o_zero_q;

	// step counters stay within their limits
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= STEPS_LAST)
		else $error("cordic step counter overran");

	a_dcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= drodo_pkg::DIV_ITERS)
		else $error("divider counter overran");

	// the distance state only moves at the end of a distance request
	a_prev_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != drodo_pkg::OP_VEND) |=> $stable(prev_time_q))
		else $error("previous time changed outside distance update");

endmodule

FILE: hdl/dead_reckoning_odometry.sv
// top level of the planar dead-reckoning odometry block
`timescale 1ns / 1ps
// Planar dead-reckoning odometry. An orientation request (cmd 1) turns the
// quaternion into a heading through a CORDIC vectoring pass and stores it with
// the yaw rate; it gives no result, and the next request can be taken once
// the heading is stored. A distance request (cmd 0) rotates the distance
// delta by the heading, adds it to the saturating position and computes
// velocity; its result is offered once the radix-4 divider (31 steps), running
// next to the CORDIC rotation, and then the multiply chain are done, and the
// next request can be taken as soon as the result is offered. One request is
// worked at a time; a finished result waits in the output register while the
// next request is taken, and a second distance result stalls in its output
// state until the first is taken. The user must write ticks_per_second over
// the cfg channel only while idle; the block does not enforce this.
module dead_reckoning_odometry #(
	parameter int CORDIC_STEPS = drodo_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_BITS   = drodo_pkg::ANGLE_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	drodo_in_if.sink    in_ch,
	drodo_out_if.source out_ch,
	drodo_cfg_if.sink   cfg_ch
);

	drodo_pkg::dp_cmd_t cmd;
	drodo_pkg::dp_sts_t sts;

	assign cfg_ch.ready = 1'b1;

	// sequencer
	drodo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	drodo_dp #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.ANGLE_BITS   (ANGLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.time_stamp     (in_ch.time_stamp),
		.distance_total (in_ch.distance_total),
		.quat_x         (in_ch.quat_x),
		.quat_y         (in_ch.quat_y),
		.quat_z         (in_ch.quat_z),
		.quat_w         (in_ch.quat_w),
		.gyro_yaw_rate  (in_ch.gyro_yaw_rate),
		.cfg_we         (cfg_ch.valid),
		.cfg_data       (cfg_ch.data),
		.pos_x          (out_ch.pos_x),
		.pos_y          (out_ch.pos_y),
		.vel_x          (out_ch.vel_x),
		.vel_y          (out_ch.vel_y),
		.heading_out    (out_ch.heading_out),
		.rate_out       (out_ch.rate_out),
		.zero_interval  (out_ch.zero_interval)
	);

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the dead-reckoning odometry block
`timescale 1ns / 1ps
module testbench;

	localparam int STEPS = drodo_pkg::CORDIC_STEPS_DEF;
	localparam int ABITS = drodo_pkg::ANGLE_BITS_DEF;

	typedef struct packed {
		logic signed [39:0] pos_x;
		logic signed [39:0] pos_y;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic [15:0]        heading_out;
		logic signed [15:0] rate_out;
		logic               zero_interval;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	drodo_in_if  in_ch ();
	drodo_out_if out_ch ();
	drodo_cfg_if cfg_ch ();

	dead_reckoning_odometry uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [29:0]        tick_rate;
	logic [31:0]        last_dist;
	logic [31:0]        prev_stamp;
	longint             acc_x;
	longint             acc_y;
	logic [15:0]        cur_heading;
	logic signed [15:0] cur_rate;
	fix_t               pending_fixes [$];
	bit                 failed = 1'b0;

	// long hold-off requests from the tests, counted out by the receiver
	int                 hold_asks = 0;
	int                 hold_taken = 0;
	int                 hold_left = 0;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint atan_step(int i);
		longint t;
		t = longint'(drodo_pkg::ATAN_TABLE[i]);
		return (t + (longint'(1) <<< (31 - ABITS))) >>> (32 - ABITS);
	endfunction

	// atan2 by vectoring
	function automatic longint vector_angle(longint x, longint y);
		longint z;
		longint nx;
		longint ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(1) <<< (ABITS - 1);
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (y < 0) begin
				nx = x - shr(y, i);
				ny = y + shr(x, i);
				z -= atan_step(i);
			end else begin
				nx = x + shr(y, i);
				ny = y - shr(x, i);
				z += atan_step(i);
			end
			x = nx;
			y = ny;
		end
		return z & ((longint'(1) <<< ABITS) - 1);
	endfunction

	// rotation mode sine and cosine, q1.30
	task automatic rotate(input longint a, output longint c, output longint s);
		longint full;
		longint z;
		longint x;
		longint y;
		longint nx;
		longint ny;
		bit neg;
		full = longint'(1) <<< ABITS;
		z = a;
		x = 652032874;
		y = 0;
		neg = 1'b0;
		if (z >= full / 2)
			z -= full;
		if (z > full / 4) begin
			z -= full / 2;
			neg = 1'b1;
		end else if (z < -full / 4) begin
			z += full / 2;
			neg = 1'b1;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - shr(y, i);
				ny = y + shr(x, i);
				z -= atan_step(i);
			end else begin
				nx = x + shr(y, i);
				ny = y - shr(x, i);
				z += atan_step(i);
			end
			x = nx;
			y = ny;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	task automatic predict_reset();
		tick_rate = drodo_pkg::TPS_RESET;
		last_dist = '0;
		prev_stamp = '0;
		acc_x = 0;
		acc_y = 0;
		cur_heading = '0;
		cur_rate = '0;
	endtask

	// model of one accepted request
	task automatic predict(input logic kind, input logic [31:0] ts, input logic [31:0] dist_mm,
			input logic signed [15:0] qx, qy, qz, qw, rate);
		longint num;
		longint den;
		longint delta;
		longint c;
		longint s;
		longint mag;
		longint speed;
		logic [31:0] elapsed;
		fix_t f;
		if (kind == drodo_pkg::CMD_ORIENTATION) begin
			num = 2 * (longint'(qw) * qz + longint'(qx) * qy);
			den = 64'sd1073741824 - 2 * (longint'(qy) * qy + longint'(qz) * qz);
			cur_heading = 16'(vector_angle(den, num) >> (ABITS - 16));
			cur_rate = rate;
			return;
		end
		delta = longint'($signed(dist_mm - last_dist));
		elapsed = ts - prev_stamp;
		rotate(longint'(cur_heading) <<< (ABITS - 16), c, s);
		acc_x = clamp(acc_x + ((delta * c + (longint'(1) <<< 21)) >>> 22), 40);
		acc_y = clamp(acc_y + ((delta * s + (longint'(1) <<< 21)) >>> 22), 40);
		f.vel_x = '0;
		f.vel_y = '0;
		if (elapsed != 0) begin
			mag = (delta < 0 ? -delta : delta) * longint'(tick_rate);
			mag = mag / longint'(elapsed);
			if (mag > 64'h7FFFFFFF)
				mag = 64'h7FFFFFFF;
			speed = delta < 0 ? -mag : mag;
			f.vel_x = 24'(clamp((speed * c + (longint'(1) <<< 29)) >>> 30, 24));
			f.vel_y = 24'(clamp((speed * s + (longint'(1) <<< 29)) >>> 30, 24));
		end
		last_dist = dist_mm;
		prev_stamp = ts;
		f.pos_x = 40'(acc_x);
		f.pos_y = 40'(acc_y);
		f.heading_out = cur_heading;
		f.rate_out = cur_rate;
		f.zero_interval = (elapsed == 0);
		pending_fixes.push_back(f);
	endtask

	// random gap, mostly short
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// send one request and wait for it to be taken
	task automatic send(input logic kind, input logic [31:0] ts, input logic [31:0] dist_mm,
			input logic signed [15:0] qx, qy, qz, qw, rate);
		int g;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= kind;
		in_ch.time_stamp <= ts;
		in_ch.distance_total <= dist_mm;
		in_ch.quat_x <= qx;
		in_ch.quat_y <= qy;
		in_ch.quat_z <= qz;
		in_ch.quat_w <= qw;
		in_ch.gyro_yaw_rate <= rate;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict(kind, ts, dist_mm, qx, qy, qz, qw, rate);
		// valid stays up when the next request follows at once
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g)
				@(posedge clk);
		end
	endtask

	task automatic send_dist(input logic [31:0] ts, input logic [31:0] dist_mm);
		send(drodo_pkg::CMD_DISTANCE, ts, dist_mm, '0, '0, '0, '0, '0);
	endtask

	task automatic send_orient(input logic signed [15:0] qx, qy, qz, qw, rate);
		send(drodo_pkg::CMD_ORIENTATION, $urandom, $urandom, qx, qy, qz, qw, rate);
	endtask

	// wait for all results, then for any orientation request still in work
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_fixes.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
	endtask

	task automatic write_rate(input logic [29:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		tick_rate = v;
		@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		fix_t got;
		fix_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.pos_x, out_ch.pos_y, out_ch.vel_x, out_ch.vel_y,
				out_ch.heading_out, out_ch.rate_out, out_ch.zero_interval};
			if (pending_fixes.size() == 0) begin
				$error("result with nothing expected");
				failed = 1'b1;
			end else begin
				want = pending_fixes.pop_front();
				if (got.pos_x !== want.pos_x) begin
					$error("pos_x expected %0d got %0d", want.pos_x, got.pos_x);
					failed = 1'b1;
				end
				if (got.pos_y !== want.pos_y) begin
					$error("pos_y expected %0d got %0d", want.pos_y, got.pos_y);
					failed = 1'b1;
				end
				if (got.vel_x !== want.vel_x) begin
					$error("vel_x expected %0d got %0d", want.vel_x, got.vel_x);
					failed = 1'b1;
				end
				if (got.vel_y !== want.vel_y) begin
					$error("vel_y expected %0d got %0d", want.vel_y, got.vel_y);
					failed = 1'b1;
				end
				if (got.heading_out !== want.heading_out) begin
					$error("heading_out expected %0d got %0d", want.heading_out,
						got.heading_out);
					failed = 1'b1;
				end
				if (got.rate_out !== want.rate_out) begin
					$error("rate_out expected %0d got %0d", want.rate_out, got.rate_out);
					failed = 1'b1;
				end
				if (got.zero_interval !== want.zero_interval) begin
					$error("zero_interval expected %0d got %0d", want.zero_interval,
						got.zero_interval);
					failed = 1'b1;
				end
			end
		end
	end

	// receiver ready with random stalls, a few long ones, and a hold-off on demand
	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else if (hold_taken != hold_asks) begin
			hold_taken <= hold_asks;
			hold_left <= 600;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 199) == 0) begin
			hold_left <= $urandom_range(20, 60);
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
	end

	task automatic test_directed();
		int q;
		send_dist(32'd0, 32'd0);
		send_dist(32'd100, 32'd1000);
		send_orient(16'sd0, 16'sd0, 16'sd23170, 16'sd23170, 16'sd32767);
		send_dist(32'd200, 32'd2000);
		send_orient(16'sd0, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
		send_dist(32'd200, 32'd3000);
		send_orient(16'sd0, 16'sd0, -16'sd23170, 16'sd23170, 16'sd1);
		send_dist(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_dist(32'h0000_0010, 32'h8000_0000);
		send_orient(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd1);
		send_orient(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd0);
		send_dist(32'h0000_0011, 32'hFFFF_FFFF);
		send_orient(16'sd0, 16'sd23170, 16'sd0, 16'sd0, 16'sd5);
		// degenerate quaternion: both atan2 operands are zero
		send_orient(16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd6);
		send_dist(32'h0000_0018, 32'h0000_0100);
		q = 23170;
		send_orient(16'sd0, 16'sd0, 16'(q), 16'sd0, 16'sd7);
		send_dist(32'h0000_0020, 32'h0000_0000);
		drain();
		write_rate('0);
		send_dist(32'h0000_0100, 32'h0001_0000);
		send_dist(32'h0000_0100, 32'h0002_0000);
		drain();
	endtask

	// large steps first one way, then the other, drive the position into saturation
	task automatic test_saturation();
		logic [31:0] d;
		write_rate(30'd1000000000);
		d = last_dist;
		for (int i = 0; i < 12; i++) begin
			d = d + 32'h7FFF_0000;
			send_dist(prev_stamp + 1, d);
		end
		for (int i = 0; i < 12; i++) begin
			d = d - 32'h7FFF_0000;
			send_dist(prev_stamp + $urandom_range(0, 2), d);
		end
		drain();
	endtask

	task automatic test_random(input int count, input logic [29:0] rate);
		logic [31:0] d;
		write_rate(rate);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_orient(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			else if ($urandom_range(0, 9) == 0)
				send_dist($urandom, $urandom);
			else begin
				d = last_dist + 32'($signed($urandom_range(0, 4000)) - 2000);
				send_dist(prev_stamp + $urandom_range(0, 3) * $urandom_range(1, 5000), d);
			end
		end
		drain();
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		hold_asks = hold_asks + 1;
		for (int i = 0; i < 12; i++)
			send_dist(prev_stamp + 500, last_dist + 32'd37);
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = drodo_pkg::CMD_DISTANCE;
		in_ch.time_stamp = '0;
		in_ch.distance_total = '0;
		in_ch.quat_x = '0;
		in_ch.quat_y = '0;
		in_ch.quat_z = '0;
		in_ch.quat_w = '0;
		in_ch.gyro_yaw_rate = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		predict_reset();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_random(250, 30'd1);
		test_backpressure();
		test_random(250, 30'($urandom_range(1, 30'h3FFF_FFFF)));
		test_random(200, 30'h3FFF_FFFF);
		drain();
		if (!failed)
			$display("dead_reckoning_odometry: match");
		else
			$display("dead_reckoning_odometry: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("dead_reckoning_odometry: mismatch");
		$finish;
	end
endmodule
